/* sv/assert_macros.svh */
// Assertion macros for the RTL of the shifter, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MSH_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");
`define MSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`define MSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");
`else
`define MSH_ASSERT_NEVER(label, clk, rst_n, cond)
`define MSH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/msh_pkg.sv */
// Shared constants and types of the multiword bit shifter.
package msh_pkg;

    localparam int WORD_WIDTH      = 32;
    localparam int MAX_WORD_OFFSET = 62;
    localparam int CNT_W           = 11;
    localparam int SEEN_W          = 7;
    localparam int SEEN_MAX        = (2 ** SEEN_W) - 1;
    localparam int OFS_W           = $clog2(MAX_WORD_OFFSET + 1);
    localparam int WORD_SHIFT      = $clog2(WORD_WIDTH);
    localparam int QUOT_W          = CNT_W - WORD_SHIFT;
    localparam int IN_DATA_W       = ((WORD_WIDTH + CNT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W      = ((WORD_WIDTH + 7) / 8) * 8;
    localparam int Q_DEPTH         = 4;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        DIR_LEFT  = 1'b0,
        DIR_RIGHT = 1'b1
    } t_dir;

    typedef logic [WORD_WIDTH-1:0] t_word;

    // One queued command: leading zeros, a main word, a tail word, trailing zeros.
    typedef struct packed {
        logic [OFS_W-1:0] pre_zeros;
        logic             has_main;
        t_word            main_word;
        logic             has_tail;
        t_word            tail_word;
        logic [OFS_W-1:0] post_zeros;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
        t_cmd cmd;
    } t_qstat;

endpackage

/* sv/msh_front.sv */
// Front end: accepts operand words, tracks the operand and builds output commands.
module msh_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tvalid,
    input  logic [msh_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic                         i_tuser,
    input  logic                         i_tlast,
    output logic                         o_tready,
    input  logic                         i_full,
    output msh_pkg::t_push               o_push,
    output logic                         o_first
);
    import msh_pkg::*;

    logic                  r_in_operand;
    t_dir                  r_dir;
    logic [CNT_W-1:0]      r_count;
    t_word                 r_prev;
    logic [SEEN_W-1:0]     r_seen;

    logic                  accept;
    logic                  first;
    t_dir                  dir;
    logic [CNT_W-1:0]      cnt;
    t_word                 prev;
    t_word                 cur;
    logic [SEEN_W-1:0]     seen;
    logic [QUOT_W-1:0]     quot;
    logic [OFS_W-1:0]      w_ofs;
    logic [WORD_SHIFT-1:0] b_ofs;
    logic [2*WORD_WIDTH-1:0] pair_l;
    logic [2*WORD_WIDTH-1:0] pair_r;
    logic [2*WORD_WIDTH-1:0] top_l;
    logic                  k_gt_w;
    logic                  k_ge_w;
    t_cmd                  cmd;

    assign o_tready = !i_full;
    assign accept   = i_tvalid && o_tready;
    assign first    = !r_in_operand;
    assign o_first  = first;

    assign dir  = first ? t_dir'(i_tuser) : r_dir;
    assign cnt  = first ? i_tdata[WORD_WIDTH +: CNT_W] : r_count;
    assign prev = first ? '0 : r_prev;
    assign seen = first ? '0 : r_seen;
    assign cur  = i_tdata[WORD_WIDTH-1:0];

    assign quot  = cnt[CNT_W-1:WORD_SHIFT];
    assign w_ofs = (32'(quot) > MAX_WORD_OFFSET) ? OFS_W'(MAX_WORD_OFFSET) : OFS_W'(quot);
    assign b_ofs = cnt[WORD_SHIFT-1:0];

    assign pair_l = {cur, prev} << b_ofs;
    assign pair_r = {cur, prev} >> b_ofs;
    assign top_l  = {{WORD_WIDTH{1'b0}}, cur} << b_ofs;

    assign k_gt_w = seen >  SEEN_W'(w_ofs);
    assign k_ge_w = seen >= SEEN_W'(w_ofs);

    always_comb begin
        cmd      = '0;
        cmd.last = i_tlast;
        unique case (dir)
            DIR_LEFT: begin
                cmd.pre_zeros = (seen == '0) ? w_ofs : '0;
                cmd.has_main  = 1'b1;
                cmd.main_word = pair_l[2*WORD_WIDTH-1:WORD_WIDTH];
                cmd.has_tail  = i_tlast;
                cmd.tail_word = top_l[2*WORD_WIDTH-1:WORD_WIDTH];
            end
            DIR_RIGHT: begin
                cmd.has_main  = k_gt_w;
                cmd.main_word = pair_r[WORD_WIDTH-1:0];
                cmd.tail_word = cur >> b_ofs;
                if (i_tlast) begin
                    if (k_ge_w) begin
                        cmd.has_tail   = 1'b1;
                        cmd.post_zeros = w_ofs;
                    end else begin
                        // Offset beyond the operand: the whole result is zeros.
                        cmd.post_zeros = OFS_W'(seen) + OFS_W'(1);
                    end
                end
            end
            default: cmd = '0;
        endcase
    end

    assign o_push.valid = accept && (dir == DIR_LEFT || k_gt_w || i_tlast);
    assign o_push.cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_operand <= 1'b0;
            r_dir        <= DIR_LEFT;
            r_count      <= '0;
            r_prev       <= '0;
            r_seen       <= '0;
        end else if (accept) begin
            r_in_operand <= !i_tlast;
            r_dir        <= dir;
            r_count      <= cnt;
            r_prev       <= cur;
            r_seen       <= (seen == SEEN_W'(SEEN_MAX)) ? seen : seen + SEEN_W'(1);
        end
    end

endmodule

/* sv/msh_queue.sv */
// Short command queue between the front end and the back end.
module msh_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  msh_pkg::t_push  i_push,
    input  logic            i_pop,
    output msh_pkg::t_qstat o_stat
);
    import msh_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.cmd   = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/msh_back.sv */
// Back end: expands queued commands into result words, one per cycle while the output is not stalled.
module msh_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  msh_pkg::t_qstat               i_qstat,
    output logic                          o_pop,
    output logic                          o_tvalid,
    output logic [msh_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                          o_tlast,
    input  logic                          i_tready
);
    import msh_pkg::*;

    logic  r_act_valid;
    t_cmd  r_act;
    logic  r_out_valid;
    t_word r_out_word;
    logic  r_out_last;

    t_cmd  n_act;
    t_word elem_word;
    logic  out_free;
    logic  emit;
    logic  final_elem;

    assign out_free = !r_out_valid || i_tready;
    assign emit     = out_free && r_act_valid;

    // Leading zeros, then main word, then tail word, then trailing zeros.
    always_comb begin
        n_act     = r_act;
        elem_word = '0;
        priority if (r_act.pre_zeros != '0) begin
            n_act.pre_zeros = r_act.pre_zeros - OFS_W'(1);
        end else if (r_act.has_main) begin
            elem_word      = r_act.main_word;
            n_act.has_main = 1'b0;
        end else if (r_act.has_tail) begin
            elem_word      = r_act.tail_word;
            n_act.has_tail = 1'b0;
        end else if (r_act.post_zeros != '0) begin
            n_act.post_zeros = r_act.post_zeros - OFS_W'(1);
        end else begin
            n_act = r_act;
        end
    end

    assign final_elem = (n_act.pre_zeros == '0) && !n_act.has_main && !n_act.has_tail
                        && (n_act.post_zeros == '0);

    assign o_pop = (!r_act_valid || (emit && final_elem)) && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act_valid <= 1'b1;
            end else if (emit && final_elem) begin
                r_act_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_act <= i_qstat.cmd;
        end else if (emit) begin
            r_act <= n_act;
        end
        if (emit) begin
            r_out_word <= elem_word;
            r_out_last <= r_act.last && final_elem;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = OUT_DATA_W'(r_out_word);
    assign o_tlast  = r_out_last;

endmodule

/* sv/multiword_bit_shifter_core.sv */
// Top level of the multiword bit shifter: front end, command queue and back end.
//
//  Channel   Direction  Payload
//  s (in)    slave      tdata = in_word, shift_count; tuser = func; tlast = last_word
//  m (out)   master     tdata = out_word; tlast = out_last
//
// Each accepted word that yields output becomes a queue command in the same cycle; the
// back end sends one result word per cycle while the output is not stalled, through
// its active command and output registers. Zero bursts at operand start or end leave
// one word at a time through the single output register, and the front stalls only
// when the four-entry queue fills. Reset is synchronous and active low; it empties
// the queue and returns the front to waiting for the first word of an operand.
`include "assert_macros.svh"
module multiword_bit_shifter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: [31:0] in_word, [42:32] shift_count, [47:43] zero
    input  logic [msh_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: [0] func
    input  logic                          i_s_tuser,
    input  logic                          i_s_tlast,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: [31:0] out_word
    output logic [msh_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready
);
    import msh_pkg::*;

    t_push  push;
    t_qstat qstat;
    logic   pop;
    logic   front_first;

    msh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .i_tdata  (i_s_tdata),
        .i_tuser  (i_s_tuser),
        .i_tlast  (i_s_tlast),
        .o_tready (o_s_tready),
        .i_full   (qstat.full),
        .o_push   (push),
        .o_first  (front_first)
    );

    msh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (qstat)
    );

    msh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast),
        .i_tready (i_m_tready)
    );

    // A command must never be written into a full queue nor read from an empty one.
    `MSH_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, push.valid && qstat.full)
    `MSH_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, pop && qstat.empty)
    // Once the last word of an operand is taken, the next word starts a new operand.
    `MSH_ASSERT_NEXT(a_operand_ends, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast, front_first)

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the multiword bit shifter core.
module testbench;
    import msh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        t_word word;
        logic  last;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tvalid;
    logic                  m_tready = 1'b0;

    multiword_bit_shifter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready)
    );

    always #1 i_clk = ~i_clk;

    t_result          shifted_words[$];
    t_result          oldest;
    int               error_count = 0;
    int               words_sent = 0;
    int               sender_idle_pct = 0;
    int               receiver_idle_pct = 0;
    int               hold_cycles = 0;
    int               quiet_cycles = 0;

    // Shadow copy of the shifter's operand state.
    t_word            prev_word = '0;
    logic             in_operand = 1'b0;
    logic [CNT_W-1:0] held_count = '0;
    t_dir             held_dir = DIR_LEFT;
    logic [SEEN_W-1:0] seen_words = '0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic t_word carry_up(t_word x, int b);
        if (b == 0)
            return '0;
        return t_word'(x >> (WORD_WIDTH - b));
    endfunction

    function automatic t_word carry_down(t_word x, int b);
        if (b == 0)
            return '0;
        return t_word'(x << (WORD_WIDTH - b));
    endfunction

    function automatic void push_shifted(t_word word, logic last);
        t_result r;
        r.word = word;
        r.last = last;
        shifted_words.push_back(r);
    endfunction

    function automatic void predict_shift(t_dir dir, t_word cur, logic [CNT_W-1:0] cnt,
                                          logic last);
        int w;
        int b;
        int k;
        if (!in_operand) begin
            held_dir   = dir;
            held_count = cnt;
            prev_word  = '0;
            seen_words = '0;
            in_operand = 1'b1;
        end
        w = held_count / WORD_WIDTH;
        if (w > MAX_WORD_OFFSET)
            w = MAX_WORD_OFFSET;
        b = held_count % WORD_WIDTH;
        k = seen_words;
        if (held_dir == DIR_LEFT) begin
            if (k == 0)
                for (int i = 0; i < w; i++) push_shifted('0, 1'b0);
            push_shifted(t_word'(cur << b) | carry_up(prev_word, b), 1'b0);
            if (last)
                push_shifted(carry_up(cur, b), 1'b1);
        end else begin
            if (k >= w + 1)
                push_shifted((prev_word >> b) | carry_down(cur, b), 1'b0);
            if (last) begin
                if (k >= w) begin
                    push_shifted(cur >> b, w == 0);
                    for (int i = 0; i < w; i++) push_shifted('0, i + 1 == w);
                end else begin
                    // The word offset swallows the whole operand: all zeros.
                    for (int i = 0; i <= k; i++) push_shifted('0, i == k);
                end
            end
        end
        prev_word = cur;
        if (seen_words < SEEN_MAX)
            seen_words = seen_words + 1'b1;
        if (last)
            in_operand = 1'b0;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Offers one request and returns once it has been accepted.
    task automatic send_word(input t_dir dir, input t_word word, input logic [CNT_W-1:0] cnt,
                             input logic last);
        @(negedge i_clk);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tdata  <= {{(IN_DATA_W - WORD_WIDTH - CNT_W){1'b0}}, cnt, word};
        s_tuser  <= dir;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predict_shift(dir, word, cnt, last);
        words_sent++;
    endtask

    // Later words carry random direction and count, which the block must ignore.
    task automatic send_operand(input t_dir dir, input int len, input logic [CNT_W-1:0] cnt);
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                send_word(dir, rand_word(), cnt, len == 1);
            else
                send_word(t_dir'($urandom_range(1)), rand_word(),
                          CNT_W'($urandom_range(2015)), i == len - 1);
        end
    endtask

    // Stops offering requests and waits until every expected word has come.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (shifted_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // Zero bit offset: the top word of a left shift is zero.
        send_word(DIR_LEFT, '1, 11'd0, 1'b1);
        send_word(DIR_LEFT, 32'h8000_0001, 11'd37, 1'b0);
        send_word(DIR_LEFT, '1, 11'd37, 1'b1);
        send_word(DIR_RIGHT, 32'h1234_5678, 11'd0, 1'b0);
        send_word(DIR_RIGHT, 32'h9ABC_DEF0, 11'd0, 1'b1);
        send_word(DIR_RIGHT, 32'hFFFF_0000, 11'd40, 1'b0);
        send_word(DIR_RIGHT, 32'h0000_FFFF, 11'd40, 1'b0);
        send_word(DIR_RIGHT, 32'hA5A5_A5A5, 11'd40, 1'b1);
        // Word offset beyond and exactly at the operand length.
        send_word(DIR_RIGHT, '1, 11'd100, 1'b0);
        send_word(DIR_RIGHT, '1, 11'd100, 1'b1);
        send_word(DIR_RIGHT, '1, 11'd64, 1'b0);
        send_word(DIR_RIGHT, '1, 11'd64, 1'b1);
        send_word(DIR_RIGHT, 32'h8000_0001, 11'd31, 1'b0);
        send_word(DIR_RIGHT, 32'h7FFF_FFFE, 11'd31, 1'b1);
        // Large counts reach the largest word offset, 62.
        send_word(DIR_LEFT, '1, 11'd2015, 1'b1);
        send_word(DIR_RIGHT, '1, 11'd2015, 1'b1);
        send_word(DIR_LEFT, 32'hDEAD_BEEF, 11'd1984, 1'b1);
        // Direction and count change mid-operand and must be ignored.
        send_word(DIR_LEFT, 32'hF000_000F, 11'd3, 1'b0);
        send_word(DIR_RIGHT, 32'h0F0F_0F0F, 11'd1500, 1'b0);
        send_word(DIR_LEFT, '0, 11'd7, 1'b1);
        drain();
    endtask

    task automatic test_long_operand();
        // Long enough for the word counter to saturate.
        send_operand(DIR_RIGHT, 130, 11'd1000);
        drain();
    endtask

    task automatic test_random(input int n);
        int first;
        int len;
        logic [CNT_W-1:0] cnt;
        first = words_sent;
        while (words_sent - first < n) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(12, 1) : $urandom_range(5, 1);
            case ($urandom_range(3))
                0: cnt = CNT_W'($urandom_range(31));
                1: cnt = CNT_W'(32 * $urandom_range(6) + $urandom_range(31));
                2: cnt = CNT_W'($urandom_range(2015));
                default: cnt = CNT_W'(32 * $urandom_range(10));
            endcase
            send_operand(t_dir'($urandom_range(1)), len, cnt);
        end
        drain();
    endtask

    task automatic test_backpressure();
        // The receiver holds off long enough for the queue to fill and stall the input.
        hold_cycles = 300;
        send_operand(DIR_LEFT, 8, 11'd45);
        send_operand(DIR_RIGHT, 4, 11'd70);
        drain();
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= !(receiver_idle_pct != 0 && $urandom_range(99) < receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (shifted_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h last %b",
                                          o_m_tdata[WORD_WIDTH-1:0], o_m_tlast));
            end else begin
                oldest = shifted_words.pop_front();
                if (o_m_tdata[WORD_WIDTH-1:0] !== oldest.word)
                    report_mismatch($sformatf("word %h, expected %h",
                                              o_m_tdata[WORD_WIDTH-1:0], oldest.word));
                if (o_m_tlast !== oldest.last)
                    report_mismatch($sformatf("last %b, expected %b", o_m_tlast, oldest.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct   = 11;
        receiver_idle_pct = 47;
        test_directed();
        test_random(4);

        sender_idle_pct   = 47;
        receiver_idle_pct = 11;
        test_long_operand();
        test_random(4);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random(4);
        test_backpressure();

        if (shifted_words.size() != 0)
            report_mismatch("expected words left over");
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
